// File: rtl/core/oct_atan_pkg.sv
// ----------------------------------------------------------------------------
// oct_atan_pkg
// Shared constants and types of the octant arctangent pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package oct_atan_pkg;

   localparam int IN_WIDTH_DEFAULT        = 16;
   localparam int RATIO_FRAC_BITS_DEFAULT = 16;

   // Cubic coefficients in 1/128 degree with 16 fraction bits.
   localparam int COEF_WIDTH = 32;
   localparam logic signed [COEF_WIDTH-1:0] COEF_A = 32'sd495097969;
   localparam logic signed [COEF_WIDTH-1:0] COEF_B = -32'sd85744719;
   localparam logic signed [COEF_WIDTH-1:0] COEF_C = -32'sd31865890;

   localparam int ANGLE_WIDTH = 16;
   localparam int OCT_WIDTH   = 3;
   localparam int FRAC_WIDTH  = 14;
   localparam logic signed [ANGLE_WIDTH:0] EIGHTH_TURN = 17'sd5760;
   localparam logic signed [ANGLE_WIDTH:0] HALF_TURN   = 17'sd23040;
   localparam logic signed [ANGLE_WIDTH:0] FULL_TURN   = 17'sd46080;
   localparam logic signed [COEF_WIDTH-1:0] ROUND_HALF = 32'sd32768;

   typedef struct packed {
      logic [OCT_WIDTH-1:0] octant;
      logic                 zero;
   } oct_ctl_type;

endpackage

`default_nettype wire

// File: rtl/core/oct_atan_reduce.sv
// ----------------------------------------------------------------------------
// oct_atan_reduce
// Folds the pair into the first octant and registers it with its octant code.
// ----------------------------------------------------------------------------
`default_nettype none

module oct_atan_reduce
   import oct_atan_pkg::*;
#(
   parameter int IN_WIDTH = IN_WIDTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire logic signed [IN_WIDTH-1:0] in_y,
   input  wire logic signed [IN_WIDTH-1:0] in_x,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output logic [IN_WIDTH:0]               out_y,
   output logic [IN_WIDTH:0]               out_x,
   output oct_ctl_type                     out_ctl
);

   logic                valid_ff;
   logic [IN_WIDTH:0]   y_ff;
   logic [IN_WIDTH:0]   x_ff;
   oct_ctl_type         ctl_ff;
   logic [IN_WIDTH:0]   y_in;
   logic [IN_WIDTH:0]   x_in;
   oct_ctl_type         ctl_in;

   always_comb begin
      logic signed [IN_WIDTH+1:0] ys;
      logic signed [IN_WIDTH+1:0] xs;
      logic signed [IN_WIDTH+1:0] tmp;
      logic [OCT_WIDTH-1:0]       oct;
      ys  = {{2{in_y[IN_WIDTH-1]}}, in_y};
      xs  = {{2{in_x[IN_WIDTH-1]}}, in_x};
      tmp = '0;
      oct = '0;
      if (ys < 0) begin
         ys     = -ys;
         xs     = -xs;
         oct[2] = 1'b1;
      end
      if (xs <= 0) begin
         tmp    = xs;
         xs     = ys;
         ys     = -tmp;
         oct[1] = 1'b1;
      end
      if (xs <= ys) begin
         tmp    = ys - xs;
         xs     = xs + ys;
         ys     = tmp;
         oct[0] = 1'b1;
      end
      // After folding both values are non-negative and y never exceeds x.
      y_in          = ys[IN_WIDTH:0];
      x_in          = xs[IN_WIDTH:0];
      ctl_in.octant = oct;
      ctl_in.zero   = (in_y == '0) && (in_x == '0);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         y_ff   <= y_in;
         x_ff   <= x_in;
         ctl_ff <= ctl_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_y     = y_ff;
   assign out_x     = x_ff;
   assign out_ctl   = ctl_ff;

endmodule

`default_nettype wire

// File: rtl/core/oct_atan_div.sv
// ----------------------------------------------------------------------------
// oct_atan_div
// Pipelined restoring divider: one quotient bit of t = y / x per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module oct_atan_div
   import oct_atan_pkg::*;
#(
   parameter int IN_WIDTH        = IN_WIDTH_DEFAULT,
   parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire logic [IN_WIDTH:0]        in_y,
   input  wire logic [IN_WIDTH:0]        in_x,
   input  wire oct_ctl_type              in_ctl,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output logic [RATIO_FRAC_BITS:0]      out_ratio,
   output oct_ctl_type                   out_ctl
);

   localparam int STAGES = RATIO_FRAC_BITS + 1;

   logic [STAGES-1:0]          valid_ff;
   logic [STAGES:0]            ready;
   logic [IN_WIDTH:0]          x_ff   [STAGES];
   logic [IN_WIDTH:0]          rem_ff [STAGES];
   logic [RATIO_FRAC_BITS:0]   quot_ff[STAGES];
   oct_ctl_type                ctl_ff [STAGES];

   assign ready[STAGES] = out_ready;

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic                       src_valid;
      logic [IN_WIDTH:0]          src_x;
      logic [IN_WIDTH:0]          src_rem;
      logic [RATIO_FRAC_BITS:0]   src_quot;
      oct_ctl_type                src_ctl;
      logic [IN_WIDTH+1:0]        rem_wide;
      logic [IN_WIDTH+1:0]        diff;
      logic                       qbit;
      logic [IN_WIDTH:0]          rem_in;
      logic [RATIO_FRAC_BITS:0]   quot_in;

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_x     = in_x;
         assign src_rem   = in_y;
         assign src_quot  = '0;
         assign src_ctl   = in_ctl;
         // The first bit carries weight one, so the remainder is not doubled.
         assign rem_wide  = {1'b0, src_rem};
      end else begin : g_rest
         assign src_valid = valid_ff[k-1];
         assign src_x     = x_ff[k-1];
         assign src_rem   = rem_ff[k-1];
         assign src_quot  = quot_ff[k-1];
         assign src_ctl   = ctl_ff[k-1];
         assign rem_wide  = {src_rem, 1'b0};
      end

      assign diff    = rem_wide - {1'b0, src_x};
      assign qbit    = rem_wide >= {1'b0, src_x};
      assign rem_in  = qbit ? diff[IN_WIDTH:0] : rem_wide[IN_WIDTH:0];
      assign quot_in = {src_quot[RATIO_FRAC_BITS-1:0], qbit};

      assign ready[k] = !valid_ff[k] || ready[k+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (ready[k]) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (ready[k] && src_valid) begin
            x_ff[k]    <= src_x;
            rem_ff[k]  <= rem_in;
            quot_ff[k] <= quot_in;
            ctl_ff[k]  <= src_ctl;
         end
      end
   end

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_ratio = quot_ff[STAGES-1];
   assign out_ctl   = ctl_ff[STAGES-1];

endmodule

`default_nettype wire

// File: rtl/core/oct_atan_poly.sv
// ----------------------------------------------------------------------------
// oct_atan_poly
// Horner evaluation of the cubic, one multiply per stage, then octant offset,
// wrap and rounding into the output register; a (0, 0) pair gives angle zero.
// ----------------------------------------------------------------------------
`default_nettype none

module oct_atan_poly
   import oct_atan_pkg::*;
#(
   parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic [RATIO_FRAC_BITS:0]      in_ratio,
   input  wire oct_ctl_type                   in_ctl,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic signed [ANGLE_WIDTH-1:0]      out_angle
);

   localparam int PROD_WIDTH = COEF_WIDTH + RATIO_FRAC_BITS + 2;

   logic [3:0] valid_ff;
   logic [4:0] ready;

   logic signed [RATIO_FRAC_BITS+1:0] t1_ff, t2_ff;
   oct_ctl_type                       ctl1_ff, ctl2_ff, ctl3_ff;
   logic signed [PROD_WIDTH-1:0]      prod1_ff, prod2_ff, prod3_ff;
   logic signed [ANGLE_WIDTH-1:0]     angle_ff;

   logic signed [RATIO_FRAC_BITS+1:0] t0;
   logic signed [PROD_WIDTH-1:0]      prod1_in, prod2_in, prod3_in;
   logic signed [PROD_WIDTH-1:0]      sh1, sh2, sh3;
   logic signed [COEF_WIDTH-1:0]      h1, h2, d, d_round;
   logic signed [ANGLE_WIDTH:0]       ang;
   logic signed [ANGLE_WIDTH-1:0]     angle_in;

   assign ready[4] = out_ready;
   for (genvar k = 0; k < 4; k++) begin : g_ready
      assign ready[k] = !valid_ff[k] || ready[k+1];
   end
   assign in_ready = ready[0];

   assign t0       = {1'b0, in_ratio};
   assign prod1_in = PROD_WIDTH'(COEF_C) * PROD_WIDTH'(t0);

   assign sh1      = prod1_ff >>> RATIO_FRAC_BITS;
   assign h1       = sh1[COEF_WIDTH-1:0] + COEF_B;
   assign prod2_in = PROD_WIDTH'(h1) * PROD_WIDTH'(t1_ff);

   assign sh2      = prod2_ff >>> RATIO_FRAC_BITS;
   assign h2       = sh2[COEF_WIDTH-1:0] + COEF_A;
   assign prod3_in = PROD_WIDTH'(h2) * PROD_WIDTH'(t2_ff);

   // The fraction is in [0, 45 degrees], so only a small slice survives rounding.
   assign sh3      = prod3_ff >>> RATIO_FRAC_BITS;
   assign d        = sh3[COEF_WIDTH-1:0];
   assign d_round  = (d + ROUND_HALF) >>> 16;

   always_comb begin
      ang = EIGHTH_TURN * $signed({1'b0, ctl3_ff.octant})
            + $signed({{(ANGLE_WIDTH+1-FRAC_WIDTH){1'b0}}, d_round[FRAC_WIDTH-1:0]});
      if (ang > HALF_TURN) begin
         ang = ang - FULL_TURN;
      end
      angle_in = ctl3_ff.zero ? '0 : ang[ANGLE_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) valid_ff[0] <= in_valid;
         if (ready[1]) valid_ff[1] <= valid_ff[0];
         if (ready[2]) valid_ff[2] <= valid_ff[1];
         if (ready[3]) valid_ff[3] <= valid_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0] && in_valid) begin
         prod1_ff <= prod1_in;
         t1_ff    <= t0;
         ctl1_ff  <= in_ctl;
      end
      if (ready[1] && valid_ff[0]) begin
         prod2_ff <= prod2_in;
         t2_ff    <= t1_ff;
         ctl2_ff  <= ctl1_ff;
      end
      if (ready[2] && valid_ff[1]) begin
         prod3_ff <= prod3_in;
         ctl3_ff  <= ctl2_ff;
      end
      if (ready[3] && valid_ff[2]) begin
         angle_ff <= angle_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign out_angle = angle_ff;

endmodule

`default_nettype wire

// File: rtl/core/octant_atan2_approximation_core.sv
// ----------------------------------------------------------------------------
// octant_atan2_approximation_core
// Four-quadrant arctangent of (y, x) in 1/128 degree via octant folding,
// a pipelined divider and a Horner cubic.
// ----------------------------------------------------------------------------
// Pipeline: one folding stage, one divider stage per quotient bit, three multiply
// stages and the output stage.
// Throughput: one item per cycle while the output is not stalled; every stage
// holds its item and fills bubbles while the output is stalled.
// Reset: synchronous, active high; clears all valid bits, payload is not reset.
`default_nettype none

module octant_atan2_approximation_core
   import oct_atan_pkg::*;
#(
   parameter int IN_WIDTH        = IN_WIDTH_DEFAULT,
   parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // Fields from bit 0: y_value, x_value, zero fill to whole bytes.
   input  wire logic [((2*IN_WIDTH+7)/8)*8-1:0]      req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // Fields from bit 0: angle_deg.
   output logic [ANGLE_WIDTH-1:0]                    rsp_tdata
);

   logic                       red_valid, red_ready;
   logic [IN_WIDTH:0]          red_y, red_x;
   oct_ctl_type                red_ctl;
   logic                       div_valid, div_ready;
   logic [RATIO_FRAC_BITS:0]   div_ratio;
   oct_ctl_type                div_ctl;
   logic signed [ANGLE_WIDTH-1:0] angle;

   oct_atan_reduce #(
      .IN_WIDTH (IN_WIDTH)
   ) u_reduce (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_y      ($signed(req_tdata[IN_WIDTH-1:0])),
      .in_x      ($signed(req_tdata[2*IN_WIDTH-1:IN_WIDTH])),
      .out_valid (red_valid),
      .out_ready (red_ready),
      .out_y     (red_y),
      .out_x     (red_x),
      .out_ctl   (red_ctl)
   );

   oct_atan_div #(
      .IN_WIDTH        (IN_WIDTH),
      .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (red_valid),
      .in_ready  (red_ready),
      .in_y      (red_y),
      .in_x      (red_x),
      .in_ctl    (red_ctl),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_ratio (div_ratio),
      .out_ctl   (div_ctl)
   );

   oct_atan_poly #(
      .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
   ) u_poly (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_ratio  (div_ratio),
      .in_ctl    (div_ctl),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_angle (angle)
   );

   assign rsp_tdata = angle;

endmodule

`default_nettype wire

// File: tb/sv/tb_octant_atan2_approximation_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_octant_atan2_approximation_core
// Streams signed (y, x) pairs into the octant arctangent core and checks every
// angle against a bit-exact fixed-point predictor. The pairs start with axes,
// diagonals, extremes and the wrap at a full turn, then continue with random
// pairs. Both ports idle and stall at random, with some stretches at full rate.
// ----------------------------------------------------------------------------

class angle_scoreboard;
   logic [oct_atan_pkg::ANGLE_WIDTH-1:0] pending_angles[$];
   int mismatches;
   int pairs_noted;
   int angles_checked;

   function new();
      mismatches     = 0;
      pairs_noted    = 0;
      angles_checked = 0;
   endfunction

   // Fold to the first octant, evaluate the cubic on the truncated ratio and
   // add back the octant, all in 1/128 degree.
   function logic [oct_atan_pkg::ANGLE_WIDTH-1:0] predict_angle(
      input logic signed [15:0] y_in, input logic signed [15:0] x_in);
      localparam int FRAC = oct_atan_pkg::RATIO_FRAC_BITS_DEFAULT;
      longint y, x, octant, swap, ratio, horner, deg, angle;
      y      = y_in;
      x      = x_in;
      octant = 0;
      if (y == 0 && x == 0) return '0;
      if (y < 0) begin
         x      = -x;
         y      = -y;
         octant += 4;
      end
      if (x <= 0) begin
         swap   = x;
         x      = y;
         y      = -swap;
         octant += 2;
      end
      if (x <= y) begin
         swap   = y - x;
         x      = x + y;
         y      = swap;
         octant += 1;
      end
      if (x <= 0) ratio = 0;
      else ratio = (y <<< FRAC) / x;
      horner = ((oct_atan_pkg::COEF_C * ratio) >>> FRAC) + oct_atan_pkg::COEF_B;
      horner = ((horner * ratio) >>> FRAC) + oct_atan_pkg::COEF_A;
      deg    = (horner * ratio) >>> FRAC;
      deg    = (deg + oct_atan_pkg::ROUND_HALF) >>> 16;
      angle  = octant * oct_atan_pkg::EIGHTH_TURN + deg;
      if (angle > oct_atan_pkg::HALF_TURN) angle -= oct_atan_pkg::FULL_TURN;
      return angle[oct_atan_pkg::ANGLE_WIDTH-1:0];
   endfunction

   function void note_pair(input logic signed [15:0] y, input logic signed [15:0] x);
      pending_angles.push_back(predict_angle(y, x));
      pairs_noted++;
   endfunction

   function void check_angle(input logic [oct_atan_pkg::ANGLE_WIDTH-1:0] actual);
      logic [oct_atan_pkg::ANGLE_WIDTH-1:0] expected;
      if (pending_angles.size() == 0) begin
         $error("angle_deg arrived with no pair outstanding: got %0d", $signed(actual));
         mismatches++;
         return;
      end
      expected = pending_angles.pop_front();
      angles_checked++;
      if (actual !== expected) begin
         $error("angle_deg mismatch: expected %0d, got %0d",
                $signed(expected), $signed(actual));
         mismatches++;
      end
   endfunction
endclass

module tb_octant_atan2_approximation_core;
   import oct_atan_pkg::*;

   localparam int STUCK_LIMIT   = 2000;
   localparam int RANDOM_BLOCKS = 6;
   localparam int BLOCK_PAIRS   = 100;
   localparam int DIRECTED_N    = 23;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;    // y_value [15:0], x_value [31:16]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // angle_deg [15:0]

   bit sender_idle_on = 1'b1;
   bit rsp_stall_on   = 1'b1;
   int stall_left     = 0;
   int stuck_cycles   = 0;

   int directed_y[DIRECTED_N] = '{0, 0, 0, 1, -1, 0, 0, 32767, -32768, 32767, -32768,
                                  32767, -32768, 1, -1, 1, -1, 100, -1, -1, 12345,
                                  -30000, 5};
   int directed_x[DIRECTED_N] = '{0, 1, -1, 0, 0, 32767, -32768, 0, 0, 32767, -32768,
                                  -32768, 32767, 1, -1, -1, 1, -100, 32767, 1000,
                                  -23456, 5, -30000};
   int corner_vals[5] = '{-32768, -1, 0, 1, 32767};

   angle_scoreboard angles = new();

   octant_atan2_approximation_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Mostly back-to-back, sometimes a short gap, now and then a long gap.
   function automatic int idle_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_stall_on && $urandom_range(0, 3) == 0) begin
         stall_left = idle_gap();
         rsp_tready <= (stall_left == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) angles.check_angle(rsp_tdata);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic send_pair(input logic signed [15:0] y, input logic signed [15:0] x);
      int idle;
      idle = sender_idle_on ? idle_gap() : 0;
      repeat (idle) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {x, y};
      do @(posedge clock); while (!req_tready);
      angles.note_pair(y, x);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (angles.pending_angles.size() != 0) @(posedge clock);
   endtask

   initial begin
      int i, b, kind, m, ry, rx;
      logic signed [15:0] y, x;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED_N; i++) send_pair(16'(directed_y[i]), 16'(directed_x[i]));
      // Let the pipeline empty completely before the random traffic starts.
      wait_drained();

      for (b = 0; b < RANDOM_BLOCKS; b++) begin
         sender_idle_on = (b == 0) ? 1'b0 : (b == 1) ? 1'b1 : 1'($urandom_range(0, 1));
         rsp_stall_on   = (b == 0) ? 1'b0 : (b == 1) ? 1'b1 : 1'($urandom_range(0, 1));
         for (i = 0; i < BLOCK_PAIRS; i++) begin
            kind = $urandom_range(0, 9);
            case (kind)
               0, 1, 2, 3: begin
                  ry = $urandom;
                  rx = $urandom;
               end
               4: begin
                  ry = int'($urandom_range(0, 16)) - 8;
                  rx = int'($urandom_range(0, 16)) - 8;
               end
               5: begin
                  m  = int'($urandom_range(0, 65535)) - 32768;
                  ry = $urandom_range(0, 1) ? m : 0;
                  rx = (ry == 0) ? m : 0;
               end
               6: begin
                  m  = $urandom_range(1, 32767);
                  ry = $urandom_range(0, 1) ? -m : m;
                  rx = $urandom_range(0, 1) ? -m : m;
               end
               7: begin
                  ry = corner_vals[$urandom_range(0, 4)];
                  rx = corner_vals[$urandom_range(0, 4)];
               end
               8: begin
                  // Close to a diagonal, where the ratio after folding is near one or near zero.
                  m  = $urandom_range(4, 32000);
                  rx = $urandom_range(0, 1) ? -m : m;
                  ry = m + int'($urandom_range(0, 6)) - 3;
                  if ($urandom_range(0, 1)) ry = -ry;
               end
               default: begin
                  // Just below the positive x axis, where the angle wraps to zero or just below.
                  ry = -int'($urandom_range(1, 4));
                  rx = $urandom_range(1000, 32767);
               end
            endcase
            y = ry[15:0];
            x = rx[15:0];
            send_pair(y, x);
         end
      end

      wait_drained();
      repeat (40) @(posedge clock);

      if (angles.pending_angles.size() != 0) begin
         $error("%0d angle_deg results never arrived", angles.pending_angles.size());
         angles.mismatches++;
      end
      $display("Sent %0d (y, x) pairs and checked %0d angles.",
               angles.pairs_noted, angles.angles_checked);
      $display("Covered axes, diagonals, extreme values, the full-turn wrap and random pairs.");
      if (angles.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/oct_atan_pkg.sv
rtl/core/oct_atan_reduce.sv
rtl/core/oct_atan_div.sv
rtl/core/oct_atan_poly.sv
rtl/core/octant_atan2_approximation_core.sv
tb/sv/tb_octant_atan2_approximation_core.sv
